// ===== hw/rtl/edt_pkg.sv =====
// Shared types and constants of the encoder detent tracker.
// Used by the top level, the serial divider and the port checker; no dependencies.
package edt_pkg;

    localparam int unsigned POS_W    = 32;  // positions, counters, time stamps
    localparam int unsigned CPD_W    = 8;   // counts per detent
    localparam int unsigned DEB_W    = 16;  // debounce time
    localparam int unsigned REM_W    = 9;   // signed sub-detent remainder
    localparam int unsigned CFG_IDX_W = 4;
    localparam int unsigned CFG_DAT_W = 16;
    localparam int unsigned DIV_CNT_W = $clog2(POS_W);

    localparam logic [CPD_W-1:0] CPD_RESET = 8'd4;
    localparam logic [DEB_W-1:0] DEB_RESET = 16'd20;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_COUNTS_PER_DETENT = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_MS       = 4'd1;

    // request codes
    localparam logic REQ_ANCHOR = 1'b0;
    localparam logic REQ_UPDATE = 1'b1;

    // direction codes shared by the remainder and the phase tracker
    localparam logic [1:0] DIR_NONE = 2'd0;
    localparam logic [1:0] DIR_POS  = 2'd1;
    localparam logic [1:0] DIR_NEG  = 2'd3;

    typedef struct packed {
        logic                    req_type;
        logic [POS_W-1:0]        now_ms;
        logic signed [POS_W-1:0] raw_position;
        logic                    phase_a;
        logic                    phase_b;
        logic                    button_raw;
    } edt_in_t;

    typedef struct packed {
        logic                    changed;
        logic                    button_changed;
        logic                    button_active;
        logic signed [POS_W-1:0] logical_position;
        logic [POS_W-1:0]        detent_count;
        logic [POS_W-1:0]        partial_reverse_count;
        logic [POS_W-1:0]        phase_mismatch_count;
    } edt_out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DELTA,
        ST_SUM,
        ST_START,
        ST_DIV,
        ST_FIX,
        ST_APPLY,
        ST_OUT
    } edt_state_t;

    // Gray phase index: AB 00 -> 0, 01 -> 1, 11 -> 2, 10 -> 3
    function automatic logic [1:0] phase_of(input logic a, input logic b);
        return {a, a ^ b};
    endfunction

endpackage

// ===== hw/rtl/encoder_detent_tracker_top.sv =====
// Top level of the rotary encoder detent tracker with debounced push button.
// Depends on edt_pkg and instantiates the serial divider edt_div.
//
// The block takes one transaction at a time. An update whose raw count did
// not move (or that arrives before the first anchor) goes from the difference
// step straight to the output step. An anchor transaction, or an update whose
// raw count moved, passes through difference, sum, the 32-iteration serial
// divider that splits the remainder sum into whole detents, sign fix and apply
// before the output step. The sequencer returns to idle at the edge that loads
// the result. s_ready is high only while the sequencer is idle; a finished
// result sits in the output register until taken, and the next transaction
// may be accepted meanwhile. Configuration writes are always taken (cfg_ready
// is tied high) and are expected only while no transaction is in progress.
module encoder_detent_tracker_top (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  edt_pkg::edt_in_t                s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output edt_pkg::edt_out_t               m_data,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [edt_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [edt_pkg::CFG_DAT_W-1:0]   cfg_data
);
    import edt_pkg::*;

    // configuration
    logic [CPD_W-1:0] cpd_reg;
    logic [DEB_W-1:0] deb_reg;

    // sequencer
    edt_state_t state_reg, state_next;
    logic       ld_item, div_start, out_load;

    // tracker state
    logic [POS_W-1:0]        last_raw_reg;
    logic signed [REM_W-1:0] rem_reg;
    logic [1:0]              rem_dir_reg;
    logic [POS_W-1:0]        detent_pos_reg;
    logic [POS_W-1:0]        detents_reg;
    logic [POS_W-1:0]        reversals_reg;
    logic [POS_W-1:0]        mismatches_reg;
    logic                    btn_stable_reg;
    logic                    btn_last_reg;
    logic [POS_W-1:0]        btn_time_reg;
    logic [POS_W-1:0]        anchor_raw_reg;
    logic [1:0]              anchor_phase_reg;
    logic [1:0]              phase_dir_reg;
    logic                    anchored_reg;

    // per-transaction working registers
    edt_in_t              item_reg;
    logic                 bchg_reg;
    logic                 move_reg;
    logic [POS_W-1:0]     delta_reg;
    logic [POS_W:0]       sum_reg;
    logic [POS_W-1:0]     q_reg;
    logic [POS_W-1:0]     quo_abs_reg;
    logic                 m_valid_reg;
    edt_out_t             m_data_reg;

    // delta stage decode
    logic             is_anchor;
    logic [1:0]       ph_obs;
    logic             btn_diff;
    logic [POS_W-1:0] btn_time_eff;
    logic [POS_W-1:0] elapsed;
    logic             deb_hit;
    logic             move;
    logic [1:0]       off2;
    logic [1:0]       fwd_ph, rev_ph;
    logic             fwd_hit, rev_hit;
    logic             mis;
    logic             dir_set;
    logic [1:0]       dir_new;

    // sum and fix stage decode
    logic [1:0]       delta_dir;
    logic             reverse_hit;
    logic             sum_neg;
    logic [POS_W:0]   sum_mag;
    logic [CPD_W-1:0] dvs_eff;
    logic [POS_W-1:0] div_quo;
    logic [CPD_W-1:0] div_rmd;
    logic             div_done;
    logic [REM_W-1:0] rem_fixed;

    assign cfg_ready = 1'b1;
    assign s_ready   = ld_item;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    // a zero register value divides by one
    assign dvs_eff = (cpd_reg == '0) ? CPD_W'(1) : cpd_reg;

    // ---------------------------------------------------------------------
    // Button debounce, raw movement and Gray phase plausibility
    // ---------------------------------------------------------------------
    always_comb begin
        is_anchor    = (item_reg.req_type == REQ_ANCHOR);
        ph_obs       = phase_of(item_reg.phase_a, item_reg.phase_b);
        btn_diff     = (item_reg.button_raw != btn_last_reg);
        // a fresh level change restarts the debounce window now
        btn_time_eff = btn_diff ? item_reg.now_ms : btn_time_reg;
        elapsed      = item_reg.now_ms - btn_time_eff;
        deb_hit      = (elapsed >= POS_W'(deb_reg)) && (btn_stable_reg != item_reg.button_raw);
        move         = anchored_reg && (item_reg.raw_position != last_raw_reg);

        // predict the phase from the anchor in both directions
        off2    = item_reg.raw_position[1:0] - anchor_raw_reg[1:0];
        fwd_ph  = anchor_phase_reg + off2;
        rev_ph  = anchor_phase_reg - off2;
        fwd_hit = (ph_obs == fwd_ph);
        rev_hit = (ph_obs == rev_ph);
        dir_set = 1'b0;
        dir_new = phase_dir_reg;
        if (item_reg.raw_position == anchor_raw_reg) begin
            mis = (ph_obs != anchor_phase_reg);
        end else if (phase_dir_reg == DIR_NONE) begin
            // infer the direction only when exactly one prediction agrees
            dir_set = (fwd_hit != rev_hit);
            dir_new = fwd_hit ? DIR_POS : DIR_NEG;
            mis     = !fwd_hit && !rev_hit;
        end else begin
            mis = (phase_dir_reg == DIR_POS) ? !fwd_hit : !rev_hit;
        end
    end

    // reversal inside a partial detent, then magnitude for the divider
    always_comb begin
        delta_dir   = delta_reg[POS_W-1] ? DIR_NEG : DIR_POS;
        reverse_hit = (rem_dir_reg != DIR_NONE) && (delta_dir != rem_dir_reg) &&
                      (rem_reg != '0);
        sum_neg     = sum_reg[POS_W];
        sum_mag     = sum_neg ? (~sum_reg + (POS_W+1)'(1)) : sum_reg;
        rem_fixed   = sum_neg ? (~{1'b0, div_rmd} + REM_W'(1)) : {1'b0, div_rmd};
    end

    edt_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (sum_mag[POS_W-1:0]),
        .divisor   (dvs_eff),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rmd)
    );

    // ---------------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (s_valid) state_next = ST_DELTA;
            ST_DELTA: state_next = (is_anchor || move) ? ST_SUM : ST_OUT;
            ST_SUM:   state_next = ST_START;
            ST_START: state_next = ST_DIV;
            ST_DIV:   if (div_done) state_next = ST_FIX;
            ST_FIX:   state_next = ST_APPLY;
            ST_APPLY: state_next = ST_OUT;
            ST_OUT:   if (!m_valid_reg || m_ready) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        ld_item   = (state_reg == ST_IDLE);
        div_start = (state_reg == ST_START);
        // load the result once the output register is free or being drained
        out_load  = (state_reg == ST_OUT) && (!m_valid_reg || m_ready);
    end

    // ---------------------------------------------------------------------
    // Datapath
    // ---------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            m_valid_reg      <= 1'b0;
            cpd_reg          <= CPD_RESET;
            deb_reg          <= DEB_RESET;
            last_raw_reg     <= '0;
            rem_reg          <= '0;
            rem_dir_reg      <= DIR_NONE;
            detent_pos_reg   <= '0;
            detents_reg      <= '0;
            reversals_reg    <= '0;
            mismatches_reg   <= '0;
            btn_stable_reg   <= 1'b0;
            btn_last_reg     <= 1'b0;
            btn_time_reg     <= '0;
            anchor_raw_reg   <= '0;
            anchor_phase_reg <= '0;
            phase_dir_reg    <= DIR_NONE;
            anchored_reg     <= 1'b0;
        end else begin
            state_reg <= state_next;

            if (cfg_valid) begin
                case (cfg_index)
                    CFG_COUNTS_PER_DETENT: cpd_reg <= cfg_data[CPD_W-1:0];
                    CFG_DEBOUNCE_MS:       deb_reg <= cfg_data[DEB_W-1:0];
                    default: ;
                endcase
            end

            if (ld_item && s_valid) begin
                item_reg <= s_data;
            end

            if (state_reg == ST_DELTA) begin
                delta_reg <= item_reg.raw_position - last_raw_reg;
                if (is_anchor) begin
                    // restart everything from these samples
                    bchg_reg         <= 1'b0;
                    move_reg         <= 1'b0;
                    last_raw_reg     <= item_reg.raw_position;
                    detents_reg      <= '0;
                    reversals_reg    <= '0;
                    mismatches_reg   <= '0;
                    btn_stable_reg   <= item_reg.button_raw;
                    btn_last_reg     <= item_reg.button_raw;
                    btn_time_reg     <= item_reg.now_ms;
                    anchor_raw_reg   <= item_reg.raw_position;
                    anchor_phase_reg <= ph_obs;
                    phase_dir_reg    <= DIR_NONE;
                    anchored_reg     <= 1'b1;
                end else begin
                    bchg_reg <= deb_hit;
                    move_reg <= move;
                    if (btn_diff) begin
                        btn_last_reg <= item_reg.button_raw;
                        btn_time_reg <= item_reg.now_ms;
                    end
                    if (deb_hit) begin
                        btn_stable_reg <= item_reg.button_raw;
                    end
                    if (move) begin
                        last_raw_reg <= item_reg.raw_position;
                        if (mis) begin
                            // re-anchor on an implausible phase
                            mismatches_reg   <= mismatches_reg + POS_W'(1);
                            anchor_raw_reg   <= item_reg.raw_position;
                            anchor_phase_reg <= ph_obs;
                            phase_dir_reg    <= DIR_NONE;
                        end else if (dir_set) begin
                            phase_dir_reg <= dir_new;
                        end
                    end
                end
            end

            if (state_reg == ST_SUM) begin
                if (is_anchor) begin
                    sum_reg <= {item_reg.raw_position[POS_W-1], item_reg.raw_position};
                end else begin
                    sum_reg <= {{(POS_W+1-REM_W){rem_reg[REM_W-1]}}, rem_reg} +
                               {delta_reg[POS_W-1], delta_reg};
                    if (reverse_hit) begin
                        reversals_reg <= reversals_reg + POS_W'(1);
                    end
                end
            end

            if (state_reg == ST_FIX) begin
                // truncating division: quotient and remainder take the sum's sign
                q_reg       <= sum_neg ? (~div_quo + POS_W'(1)) : div_quo;
                quo_abs_reg <= div_quo;
                rem_reg     <= rem_fixed;
                rem_dir_reg <= (div_rmd == '0) ? DIR_NONE : (sum_neg ? DIR_NEG : DIR_POS);
            end

            if (state_reg == ST_APPLY) begin
                if (is_anchor) begin
                    detent_pos_reg <= q_reg;
                end else begin
                    detent_pos_reg <= detent_pos_reg + q_reg;
                    detents_reg    <= detents_reg + quo_abs_reg;
                end
            end

            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // result payload; holds while the consumer stalls
    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_data_reg.changed               <= bchg_reg | move_reg;
            m_data_reg.button_changed        <= bchg_reg;
            m_data_reg.button_active         <= btn_stable_reg;
            m_data_reg.logical_position      <= detent_pos_reg;
            m_data_reg.detent_count          <= detents_reg;
            m_data_reg.partial_reverse_count <= reversals_reg;
            m_data_reg.phase_mismatch_count  <= mismatches_reg;
        end
    end

endmodule

// ===== hw/rtl/edt_div.sv =====
// Serial restoring divider: unsigned 32-bit dividend by 8-bit divisor, one bit per cycle.
// Depends on edt_pkg for widths.
module edt_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [edt_pkg::POS_W-1:0]   dividend,
    input  logic [edt_pkg::CPD_W-1:0]   divisor,
    output logic                        done,
    output logic [edt_pkg::POS_W-1:0]   quotient,
    output logic [edt_pkg::CPD_W-1:0]   remainder
);
    import edt_pkg::*;

    logic                 run_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [POS_W-1:0]     quo_reg;
    logic [CPD_W-1:0]     acc_reg;
    logic [CPD_W-1:0]     dvs_reg;
    logic [CPD_W:0]       trial;
    logic                 fits;

    // shift in the next dividend bit and try to subtract
    always_comb begin
        trial = {acc_reg, quo_reg[POS_W-1]};
        fits  = (trial >= {1'b0, dvs_reg});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= run_reg && (cnt_reg == DIV_CNT_W'(POS_W - 1));
            if (start) begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
                quo_reg <= dividend;
                acc_reg <= '0;
                dvs_reg <= divisor;
            end else if (run_reg) begin
                cnt_reg <= cnt_reg + DIV_CNT_W'(1);
                if (cnt_reg == DIV_CNT_W'(POS_W - 1)) begin
                    run_reg <= 1'b0;
                end
                acc_reg <= fits ? CPD_W'(trial - {1'b0, dvs_reg}) : trial[CPD_W-1:0];
                quo_reg <= {quo_reg[POS_W-2:0], fits};
            end
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = acc_reg;

endmodule

// ===== hw/rtl/edt_checker.sv =====
// Port-level checker for the encoder detent tracker, bound to the top level.
// Depends on edt_pkg for the payload types.
module edt_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    input  logic                            s_ready,
    input  logic                            m_valid,
    input  logic                            m_ready,
    input  edt_pkg::edt_out_t               m_data
);
    import edt_pkg::*;

    logic       s_acc, m_acc;
    logic [1:0] open_reg;

    assign s_acc = s_valid && s_ready;
    assign m_acc = m_valid && m_ready;

    // transactions taken in but not yet delivered
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            open_reg <= '0;
        end else begin
            open_reg <= open_reg + {1'b0, s_acc} - {1'b0, m_acc};
        end
    end

    // one transaction at a time: not ready right after an accept
    assert property (@(posedge aclk) disable iff (!aresetn) s_acc |=> !s_ready)
        else $error("input accepted while previous transaction in progress");

    // at most one in work and one waiting in the output register
    assert property (@(posedge aclk) disable iff (!aresetn) open_reg != 2'd3)
        else $error("too many open transactions");

    // no result without a transaction behind it
    assert property (@(posedge aclk) disable iff (!aresetn) m_valid |-> open_reg != 2'd0)
        else $error("result with no open transaction");

    // a debounced button change always marks the result as changed
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.button_changed |-> m_data.changed)
        else $error("button change without changed flag");

    // stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result dropped or changed while stalled");

endmodule

bind encoder_detent_tracker_top edt_checker u_edt_checker (.*);

// ===== sim/tb_encoder_detent_tracker_top.sv =====
// Self-checking testbench of encoder_detent_tracker_top: a short table of directed transactions, then
// random encoder walks under several register settings and idle patterns.
// Depends on edt_pkg and the RTL of encoder_detent_tracker_top only.
module tb_encoder_detent_tracker_top;
    import edt_pkg::*;

    // index that decodes to no register; writes to it must leave the block unchanged
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 4'd9;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned TAIL_CYCLES   = 60;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    edt_in_t               s_data    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    edt_out_t              m_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DAT_W-1:0]  cfg_data  = '0;

    encoder_detent_tracker_top DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    // idle percentages of both sides, and the long hold-off of the receiver
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    logic        stall_results = 1'b0;
    int unsigned fail_count    = 0;

    // results still owed by the block, oldest first
    edt_out_t pending_reports[$];

    // ------------------------------------------------------------------
    // Tracker state as the block should hold it
    // ------------------------------------------------------------------
    logic [CPD_W-1:0]        trk_cpd         = CPD_RESET;
    logic [DEB_W-1:0]        trk_deb         = DEB_RESET;
    logic [POS_W-1:0]        trk_last_raw    = '0;
    logic signed [REM_W-1:0] trk_rem         = '0;
    logic [1:0]              trk_rem_dir     = DIR_NONE;
    logic [POS_W-1:0]        trk_pos         = '0;
    logic [POS_W-1:0]        trk_detents     = '0;
    logic [POS_W-1:0]        trk_reversals   = '0;
    logic [POS_W-1:0]        trk_mismatches  = '0;
    logic                    trk_btn_stable  = 1'b0;
    logic                    trk_btn_sample  = 1'b0;
    logic [POS_W-1:0]        trk_btn_time    = '0;
    logic [POS_W-1:0]        trk_anchor_raw  = '0;
    logic [1:0]              trk_anchor_ph   = 2'd0;
    logic [1:0]              trk_phase_dir   = DIR_NONE;
    logic                    trk_anchored    = 1'b0;

    function automatic logic [1:0] dir_of(input longint v);
        return (v > 0) ? DIR_POS : ((v < 0) ? DIR_NEG : DIR_NONE);
    endfunction

    // Gray phase index of the A/B levels
    function automatic logic [1:0] gray_index(input logic a, input logic b);
        case ({a, b})
            2'b00: return 2'd0;
            2'b01: return 2'd1;
            2'b11: return 2'd2;
            default: return 2'd3;
        endcase
    endfunction

    // phase check failed: count it and re-anchor on this sample
    function automatic void flag_phase_fault(input logic [POS_W-1:0] raw, input logic [1:0] ph);
        trk_mismatches = trk_mismatches + 1;
        trk_anchor_raw = raw;
        trk_anchor_ph  = ph;
        trk_phase_dir  = DIR_NONE;
    endfunction

    // Advance the tracker state by one transaction and return the report it produces.
    function automatic edt_out_t track_update(input edt_in_t it);
        longint           divs, num, quo, mag, dlt;
        logic [POS_W-1:0] diff, off, elapsed;
        logic [1:0]       ph, fwd, rev;
        logic             fm, rm, settled, bchg, moved;
        edt_out_t         rep;

        divs = (trk_cpd == '0) ? 1 : longint'(trk_cpd);
        ph   = gray_index(it.phase_a, it.phase_b);
        bchg  = 1'b0;
        moved = 1'b0;

        if (it.req_type == REQ_ANCHOR) begin
            num = longint'($signed(it.raw_position));
            quo = num / divs;
            trk_last_raw   = it.raw_position;
            trk_pos        = quo[POS_W-1:0];
            trk_rem        = REM_W'(num - quo * divs);
            trk_rem_dir    = dir_of(longint'(trk_rem));
            trk_detents    = '0;
            trk_reversals  = '0;
            trk_mismatches = '0;
            trk_btn_stable = it.button_raw;
            trk_btn_sample = it.button_raw;
            trk_btn_time   = it.now_ms;
            trk_anchor_raw = it.raw_position;
            trk_anchor_ph  = ph;
            trk_phase_dir  = DIR_NONE;
            trk_anchored   = 1'b1;
        end else begin
            // debounce: restart the timer on every change of the raw level
            if (it.button_raw != trk_btn_sample) begin
                trk_btn_sample = it.button_raw;
                trk_btn_time   = it.now_ms;
            end
            elapsed = it.now_ms - trk_btn_time;
            if (elapsed >= {16'd0, trk_deb} && trk_btn_stable != it.button_raw) begin
                trk_btn_stable = it.button_raw;
                bchg = 1'b1;
            end

            if (trk_anchored && it.raw_position != trk_last_raw) begin
                moved = 1'b1;
                diff = it.raw_position - trk_last_raw;
                dlt  = longint'($signed(diff));
                trk_last_raw = it.raw_position;

                // fold into the remainder, take whole detents out
                if (dir_of(dlt) != DIR_NONE && trk_rem_dir != DIR_NONE &&
                    dir_of(dlt) != trk_rem_dir && trk_rem != 0)
                    trk_reversals = trk_reversals + 1;
                num = longint'(trk_rem) + dlt;
                quo = num / divs;
                mag = (quo < 0) ? -quo : quo;
                trk_rem     = REM_W'(num - quo * divs);
                trk_pos     = trk_pos + quo[POS_W-1:0];
                trk_detents = trk_detents + mag[POS_W-1:0];
                trk_rem_dir = dir_of(longint'(trk_rem));

                // phase plausibility against the anchor
                off = it.raw_position - trk_anchor_raw;
                fwd = trk_anchor_ph + off[1:0];
                rev = trk_anchor_ph - off[1:0];
                if (off == '0) begin
                    if (ph != trk_anchor_ph)
                        flag_phase_fault(it.raw_position, ph);
                end else begin
                    settled = 1'b1;
                    if (trk_phase_dir == DIR_NONE) begin
                        fm = (ph == fwd);
                        rm = (ph == rev);
                        if (fm != rm) begin
                            trk_phase_dir = fm ? DIR_POS : DIR_NEG;
                        end else begin
                            settled = 1'b0;
                            if (!fm)
                                flag_phase_fault(it.raw_position, ph);
                        end
                    end
                    if (settled && ph != ((trk_phase_dir == DIR_POS) ? fwd : rev))
                        flag_phase_fault(it.raw_position, ph);
                end
            end
        end

        rep.changed               = bchg | moved;
        rep.button_changed        = bchg;
        rep.button_active         = trk_btn_stable;
        rep.logical_position      = trk_pos;
        rep.detent_count          = trk_detents;
        rep.partial_reverse_count = trk_reversals;
        rep.phase_mismatch_count  = trk_mismatches;
        return rep;
    endfunction

    // ------------------------------------------------------------------
    // Channel drivers
    // ------------------------------------------------------------------

    // Offer one transaction; return at the edge that accepts it with valid still high.
    task automatic send_item(input edt_in_t it);
        edt_out_t rep;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        rep = track_update(it);
        pending_reports.push_back(rep);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        if (idx == CFG_COUNTS_PER_DETENT)
            trk_cpd = val[CPD_W-1:0];
        else if (idx == CFG_DEBOUNCE_MS)
            trk_deb = val[DEB_W-1:0];
        @(posedge aclk);
    endtask

    // Drop valid, then wait until every owed result has been taken and the block settles.
    task automatic wait_idle(input int unsigned extra);
        s_valid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge aclk);
        repeat (extra) @(posedge aclk);
    endtask

    task automatic check_field(input string name, input logic [POS_W-1:0] want,
                               input logic [POS_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endtask

    // Receiver: check each accepted result, then pick ready for the next cycle.
    initial begin
        edt_out_t want;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                if (pending_reports.size() == 0) begin
                    $error("result transaction with nothing outstanding");
                    fail_count++;
                end else begin
                    want = pending_reports.pop_front();
                    check_field("changed", POS_W'(want.changed), POS_W'(m_data.changed));
                    check_field("button_changed", POS_W'(want.button_changed),
                                POS_W'(m_data.button_changed));
                    check_field("button_active", POS_W'(want.button_active),
                                POS_W'(m_data.button_active));
                    check_field("logical_position", want.logical_position,
                                m_data.logical_position);
                    check_field("detent_count", want.detent_count, m_data.detent_count);
                    check_field("partial_reverse_count", want.partial_reverse_count,
                                m_data.partial_reverse_count);
                    check_field("phase_mismatch_count", want.phase_mismatch_count,
                                m_data.phase_mismatch_count);
                end
            end
            m_ready <= !stall_results && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // Directed table
    // ------------------------------------------------------------------
    typedef struct {
        edt_in_t  item;
        bit       typed;
        edt_out_t want;
    } stim_row_t;

    stim_row_t directed_rows[$];

    task automatic add_row(input logic req, input logic [POS_W-1:0] now,
                           input logic [POS_W-1:0] raw, input logic a, input logic b,
                           input logic btn, input bit typed, input edt_out_t want);
        stim_row_t row;
        row.item.req_type     = req;
        row.item.now_ms       = now;
        row.item.raw_position = raw;
        row.item.phase_a      = a;
        row.item.phase_b      = b;
        row.item.button_raw   = btn;
        row.typed             = typed;
        row.want              = want;
        directed_rows.push_back(row);
    endtask

    function automatic edt_out_t report(input logic chg, input logic bchg, input logic act,
                                        input logic [POS_W-1:0] pos, input logic [POS_W-1:0] det,
                                        input logic [POS_W-1:0] rev, input logic [POS_W-1:0] mis);
        edt_out_t r;
        r.changed               = chg;
        r.button_changed        = bchg;
        r.button_active         = act;
        r.logical_position      = pos;
        r.detent_count          = det;
        r.partial_reverse_count = rev;
        r.phase_mismatch_count  = mis;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Random encoder walk
    // ------------------------------------------------------------------
    logic [POS_W-1:0] walk_raw     = '0;
    logic [POS_W-1:0] walk_now     = 32'd1000;
    logic             walk_btn     = 1'b0;
    int               walk_heading = 1;
    logic             walk_orient  = 1'b1;
    logic [1:0]       walk_ofs     = 2'd0;

    // Mostly clean quadrature motion with bouncing button; the rest is anchors,
    // bad phases, count jumps and time jumps.
    task automatic run_walk(input int unsigned n_items);
        edt_in_t     it;
        int unsigned roll;
        int          step;
        logic [1:0]  idx;
        walk_orient = 1'($urandom_range(1));
        walk_ofs    = 2'($urandom_range(3));
        for (int unsigned k = 0; k < n_items; k++) begin
            roll = $urandom_range(99);
            if ($urandom_range(19) == 0)
                walk_now = walk_now + $urandom_range(70000);
            else
                walk_now = walk_now + $urandom_range(12);
            if ($urandom_range(24) == 0)
                walk_btn = ~walk_btn;
            if ($urandom_range(6) == 0)
                walk_heading = -walk_heading;
            case ($urandom_range(9))
                0:       step = 0;
                1, 2:    step = walk_heading * int'($urandom_range(2, 9));
                default: step = walk_heading;
            endcase
            walk_raw = walk_raw + step;
            if (roll >= 4 && roll < 7)
                walk_raw = $urandom;
            if (roll >= 7 && roll < 9)
                walk_now = $urandom;
            idx = walk_orient ? (walk_raw[1:0] + walk_ofs) : (walk_ofs - walk_raw[1:0]);

            it.req_type     = (roll < 4) ? REQ_ANCHOR : REQ_UPDATE;
            it.now_ms       = walk_now;
            it.raw_position = walk_raw;
            it.phase_a      = idx[1];
            it.phase_b      = idx[1] ^ idx[0];
            it.button_raw   = walk_btn ^ ($urandom_range(11) == 0);
            // corrupt the pins now and then
            if (roll >= 9 && roll < 16) begin
                it.phase_a = 1'($urandom_range(1));
                it.phase_b = 1'($urandom_range(1));
            end
            send_item(it);
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        edt_out_t rep;
        logic [7:0] junk;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Updates before the first anchor: button debounces, the count is ignored.
        add_row(REQ_UPDATE, 32'd100, 32'd12345, 1'b0, 1'b0, 1'b0, 1'b1,
                report(1'b0, 1'b0, 1'b0, '0, '0, '0, '0));
        add_row(REQ_UPDATE, 32'd100, 32'd12345, 1'b0, 1'b0, 1'b1, 1'b1,
                report(1'b0, 1'b0, 1'b0, '0, '0, '0, '0));
        add_row(REQ_UPDATE, 32'd120, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, 1'b1,
                report(1'b1, 1'b1, 1'b1, '0, '0, '0, '0));
        // Anchors at both ends of the count range, button taken without debounce.
        add_row(REQ_ANCHOR, 32'd200, 32'h7FFF_FFFF, 1'b1, 1'b1, 1'b0, 1'b1,
                report(1'b0, 1'b0, 1'b0, 32'd536870911, '0, '0, '0));
        add_row(REQ_ANCHOR, 32'hFFFF_FFFF, 32'h8000_0000, 1'b0, 1'b0, 1'b1, 1'b1,
                report(1'b0, 1'b0, 1'b1, 32'hE000_0000, '0, '0, '0));
        // Learn forward, reverse inside a detent, wrap the count by one.
        add_row(REQ_UPDATE, 32'd0, 32'h8000_0001, 1'b0, 1'b1, 1'b1, 1'b0, '0);
        add_row(REQ_UPDATE, 32'd1, 32'h8000_0000, 1'b0, 1'b0, 1'b1, 1'b0, '0);
        add_row(REQ_UPDATE, 32'd2, 32'h7FFF_FFFF, 1'b1, 1'b0, 1'b1, 1'b0, '0);
        // Wrong phase, then ambiguous and impossible phases while direction is unknown.
        add_row(REQ_UPDATE, 32'd3, 32'h7FFF_FFFB, 1'b1, 1'b1, 1'b1, 1'b0, '0);
        add_row(REQ_UPDATE, 32'd4, 32'h7FFF_FFFD, 1'b0, 1'b0, 1'b1, 1'b0, '0);
        add_row(REQ_UPDATE, 32'd5, 32'h7FFF_FFFF, 1'b0, 1'b1, 1'b1, 1'b0, '0);
        // Button bounce with the count at rest, then a settled release.
        add_row(REQ_UPDATE, 32'd6, 32'h7FFF_FFFF, 1'b1, 1'b1, 1'b0, 1'b0, '0);
        add_row(REQ_UPDATE, 32'd7, 32'h7FFF_FFFF, 1'b1, 1'b1, 1'b1, 1'b0, '0);
        add_row(REQ_UPDATE, 32'd26, 32'h7FFF_FFFF, 1'b1, 1'b1, 1'b0, 1'b0, '0);
        add_row(REQ_UPDATE, 32'd46, 32'h7FFF_FFFF, 1'b1, 1'b1, 1'b0, 1'b0, '0);
        // Largest count jumps, both in the negative direction.
        add_row(REQ_UPDATE, 32'd46, 32'h0000_0000, 1'b0, 1'b0, 1'b0, 1'b0, '0);
        add_row(REQ_UPDATE, 32'd47, 32'h8000_0000, 1'b1, 1'b0, 1'b0, 1'b0, '0);
        // Debounce across the time wrap.
        add_row(REQ_UPDATE, 32'hFFFF_FFFF, 32'h8000_0001, 1'b0, 1'b1, 1'b1, 1'b0, '0);
        add_row(REQ_UPDATE, 32'd19, 32'h8000_0001, 1'b0, 1'b1, 1'b1, 1'b0, '0);
        add_row(REQ_UPDATE, 32'd20, 32'h8000_0005, 1'b0, 1'b1, 1'b1, 1'b0, '0);

        // Walk the table; typed rows replace the predicted report with the literal one.
        foreach (directed_rows[i]) begin
            send_item(directed_rows[i].item);
            if (directed_rows[i].typed) begin
                rep = pending_reports.pop_back();
                pending_reports.push_back(directed_rows[i].want);
            end
        end
        wait_idle(SETTLE_CYCLES);

        // Smallest detent and no debounce; sender idles less than receiver.
        send_idle_pct = 35;
        recv_idle_pct = 57;
        write_reg(CFG_COUNTS_PER_DETENT, 16'h0001);
        write_reg(CFG_DEBOUNCE_MS, 16'h0000);
        run_walk(275);
        wait_idle(SETTLE_CYCLES);

        // Largest detent and longest debounce.
        write_reg(CFG_COUNTS_PER_DETENT, 16'h00FF);
        write_reg(CFG_DEBOUNCE_MS, 16'hFFFF);
        run_walk(275);
        wait_idle(SETTLE_CYCLES);

        // Swap idling; a zero detent size (upper data bits set) counts as one.
        send_idle_pct = 57;
        recv_idle_pct = 35;
        junk = 8'($urandom_range(1, 255));
        write_reg(CFG_COUNTS_PER_DETENT, {junk, 8'h00});
        write_reg(CFG_DEBOUNCE_MS, 16'd5);
        run_walk(275);
        wait_idle(SETTLE_CYCLES);

        // Writes to an unused index must be ignored.
        write_reg(CFG_COUNTS_PER_DETENT, 16'd24);
        write_reg(CFG_DEBOUNCE_MS, 16'd1);
        write_reg(CFG_UNUSED, 16'hA5A5);
        run_walk(275);
        wait_idle(SETTLE_CYCLES);

        // No idling; hold the receiver off for a long stretch so the block backs up.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(CFG_COUNTS_PER_DETENT, 16'd3);
        write_reg(CFG_DEBOUNCE_MS, 16'd20);
        fork
            begin
                stall_results <= 1'b1;
                repeat (400) @(posedge aclk);
                stall_results <= 1'b0;
            end
        join_none
        run_walk(275);
        wait_idle(SETTLE_CYCLES);

        // Random mid-range settings.
        write_reg(CFG_COUNTS_PER_DETENT, 16'($urandom_range(2, 254)));
        write_reg(CFG_DEBOUNCE_MS, 16'($urandom_range(0, 40)));
        run_walk(275);

        // Drain, then give the block time to show any stray result.
        wait_idle(TAIL_CYCLES);
        if (fail_count == 0)
            $display("[encoder_detent_tracker_top] OK");
        else
            $display("[encoder_detent_tracker_top] ERROR");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #10_000_000;
        $display("[encoder_detent_tracker_top] ERROR");
        $finish;
    end

endmodule
